// ===== rtl/nma_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nma_pkg
// Codes, control word layout and the microprogram of the NDEF message
// assembler.
// ----------------------------------------------------------------------------
package nma_pkg;

  // request action codes
  localparam logic [2:0] ACT_CLEAR = 3'd0;
  localparam logic [2:0] ACT_TEXT  = 3'd1;
  localparam logic [2:0] ACT_URI   = 3'd2;
  localparam logic [2:0] ACT_BODY  = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  // result status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_OVERFLOW = 2'd1;
  localparam logic [1:0] STS_SEQUENCE = 2'd2;
  localparam logic [1:0] STS_RANGE    = 2'd3;

  // message bytes
  localparam logic [7:0] TLV_NDEF       = 8'h03;
  localparam logic [7:0] TLV_END        = 8'hFE;
  localparam logic [7:0] TLV_LONG       = 8'hFF;
  localparam logic [7:0] FLAG_MB        = 8'h80;
  localparam logic [7:0] FLAG_ME        = 8'h40;
  localparam logic [7:0] FLAG_SR        = 8'h10;
  localparam logic [7:0] TNF_WELL_KNOWN = 8'h01;
  localparam logic [7:0] TYPE_TEXT      = 8'h54;
  localparam logic [7:0] TYPE_URI       = 8'h55;
  localparam logic [7:0] TYPE_LEN       = 8'h01;

  typedef logic [4:0] pc_t;
  typedef logic [3:0] op_t;
  typedef logic [3:0] wsrc_t;
  typedef logic [2:0] cond_t;

  // microprogram step addresses
  localparam pc_t PC_BEGIN = 5'd0;
  localparam pc_t PC_HDR   = 5'd1;
  localparam pc_t PC_TLEN  = 5'd2;
  localparam pc_t PC_LEN3  = 5'd3;
  localparam pc_t PC_LEN2  = 5'd4;
  localparam pc_t PC_LEN1  = 5'd5;
  localparam pc_t PC_LEN0  = 5'd6;
  localparam pc_t PC_TYPE  = 5'd7;
  localparam pc_t PC_STAT  = 5'd8;
  localparam pc_t PC_TERM  = 5'd9;
  localparam pc_t PC_BODY  = 5'd10;
  localparam pc_t PC_CLOSE = 5'd11;
  localparam pc_t PC_CLEAR = 5'd12;
  localparam pc_t PC_READ  = 5'd13;
  localparam pc_t PC_RDOUT = 5'd14;
  localparam pc_t PC_BAD   = 5'd15;
  localparam pc_t PC_FIN   = 5'd16;

  // datapath operations
  localparam op_t OP_NOP   = 4'd0;
  localparam op_t OP_BEGIN = 4'd1;
  localparam op_t OP_OPEN  = 4'd2;
  localparam op_t OP_BODY  = 4'd3;
  localparam op_t OP_CLOSE = 4'd4;
  localparam op_t OP_CLEAR = 4'd5;
  localparam op_t OP_READ  = 4'd6;
  localparam op_t OP_RDOUT = 4'd7;
  localparam op_t OP_BAD   = 4'd8;
  localparam op_t OP_FIN   = 4'd9;

  // store write data sources
  localparam wsrc_t WS_NONE   = 4'd0;
  localparam wsrc_t WS_OLDHDR = 4'd1;
  localparam wsrc_t WS_HDR    = 4'd2;
  localparam wsrc_t WS_TLEN   = 4'd3;
  localparam wsrc_t WS_LEN3   = 4'd4;
  localparam wsrc_t WS_LEN2   = 4'd5;
  localparam wsrc_t WS_LEN1   = 4'd6;
  localparam wsrc_t WS_LEN0   = 4'd7;
  localparam wsrc_t WS_TYPE   = 4'd8;
  localparam wsrc_t WS_STAT   = 4'd9;
  localparam wsrc_t WS_END    = 4'd10;
  localparam wsrc_t WS_DATA   = 4'd11;

  // jump conditions
  localparam cond_t CD_NEVER  = 3'd0;
  localparam cond_t CD_ALWAYS = 3'd1;
  localparam cond_t CD_BAD    = 3'd2;
  localparam cond_t CD_SHORT  = 3'd3;
  localparam cond_t CD_BLEN   = 3'd4;
  localparam cond_t CD_STAY   = 3'd5;

  typedef struct packed {
    op_t   op;
    wsrc_t wsrc;
    logic  wen;
    logic  at_last;
    logic  inc;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  function automatic ucode_t ucode_word(input pc_t pc);
    ucode_t w;
    w = '{op: OP_NOP, wsrc: WS_NONE, wen: 1'b0, at_last: 1'b0, inc: 1'b0,
          cond: CD_NEVER, target: PC_FIN};
    case (pc)
      PC_BEGIN: begin
        w.op = OP_BEGIN; w.wsrc = WS_OLDHDR; w.wen = 1'b1; w.at_last = 1'b1;
        w.cond = CD_BAD;
      end
      PC_HDR:   begin w.wsrc = WS_HDR;  w.wen = 1'b1; w.inc = 1'b1; end
      PC_TLEN:  begin
        w.wsrc = WS_TLEN; w.wen = 1'b1; w.inc = 1'b1;
        w.cond = CD_SHORT; w.target = PC_LEN0;
      end
      PC_LEN3:  begin w.wsrc = WS_LEN3; w.wen = 1'b1; w.inc = 1'b1; end
      PC_LEN2:  begin w.wsrc = WS_LEN2; w.wen = 1'b1; w.inc = 1'b1; end
      PC_LEN1:  begin w.wsrc = WS_LEN1; w.wen = 1'b1; w.inc = 1'b1; end
      PC_LEN0:  begin w.wsrc = WS_LEN0; w.wen = 1'b1; w.inc = 1'b1; end
      PC_TYPE:  begin w.wsrc = WS_TYPE; w.wen = 1'b1; w.inc = 1'b1; end
      PC_STAT:  begin
        w.op = OP_OPEN; w.wsrc = WS_STAT; w.wen = 1'b1; w.inc = 1'b1;
        w.cond = CD_BLEN;
      end
      PC_TERM:  begin
        w.wsrc = WS_END; w.wen = 1'b1; w.inc = 1'b1; w.cond = CD_ALWAYS;
      end
      PC_BODY:  begin
        w.op = OP_BODY; w.wsrc = WS_DATA; w.wen = 1'b1; w.inc = 1'b1;
        w.cond = CD_STAY;
      end
      PC_CLOSE: begin
        w.op = OP_CLOSE; w.wsrc = WS_END; w.wen = 1'b1; w.inc = 1'b1;
        w.cond = CD_ALWAYS;
      end
      PC_CLEAR: begin w.op = OP_CLEAR; w.cond = CD_ALWAYS; end
      PC_READ:  begin w.op = OP_READ; end
      PC_RDOUT: begin w.op = OP_RDOUT; w.cond = CD_ALWAYS; end
      PC_BAD:   begin w.op = OP_BAD;   w.cond = CD_ALWAYS; end
      PC_FIN:   begin w.op = OP_FIN; end
      default:  begin w.op = OP_FIN; end
    endcase
    return w;
  endfunction

  // first step of the program for each action
  function automatic pc_t entry_step(input logic [2:0] act);
    pc_t p;
    case (act)
      ACT_CLEAR: p = PC_CLEAR;
      ACT_TEXT:  p = PC_BEGIN;
      ACT_URI:   p = PC_BEGIN;
      ACT_BODY:  p = PC_BODY;
      ACT_READ:  p = PC_READ;
      default:   p = PC_BAD;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ndef_message_assembler_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ndef_message_assembler_core
// Builds an NDEF message inside a long-form TLV in a byte store, driven by a
// microprogram: one control word per step, step counter, conditional jumps.
// The sequencer runs one step per cycle and ends each program with a done
// strobe. busy drops with done, and the next request can be taken while
// done is high. The store write port (one byte per step) sets the program
// lengths. Reset empties the message at once, with no clearing pass;
// results cannot be stalled.
// ----------------------------------------------------------------------------
module ndef_message_assembler_core #(
  parameter int STORE_BYTES = 1024,
  parameter int PAD_BLOCK   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [10:0] body_length,
  input  logic [5:0]  record_status,
  input  logic [7:0]  data_byte,
  input  logic [9:0]  read_address,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  read_byte,
  output logic [10:0] message_length,
  output logic [10:0] padded_length,
  output logic        record_open
);
  import nma_pkg::*;

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int FW  = $clog2(STORE_BYTES + 1);
  localparam int CW  = ((FW > 12) ? FW : 12) + 1;
  localparam int MW  = $clog2(PAD_BLOCK);
  localparam logic [MW-1:0] MOD_TOP   = MW'(PAD_BLOCK - 1);
  localparam logic [MW-1:0] MOD_THREE = MW'(3 % PAD_BLOCK);
  localparam logic [MW-1:0] MOD_FOUR  = MW'(4 % PAD_BLOCK);

  // sequencer
  pc_t    pc;
  ucode_t cw;

  // latched request
  logic [2:0]  r_action;
  logic [11:0] r_payload;
  logic [10:0] r_blen;
  logic [5:0]  r_stat;
  logic [7:0]  r_data;
  logic [9:0]  r_addr;

  // message bookkeeping
  logic [FW-1:0] fill;
  logic [MW-1:0] fill_mod;
  logic [15:0]   enc_size;
  logic [FW-1:0] last_pos;
  logic [7:0]    last_hdr;
  logic [10:0]   remaining;
  logic          open_flag;
  logic [7:0]    rd_q;

  logic [7:0] mem [STORE_BYTES];

  logic          is_short;
  logic [FW-1:0] start_pos;
  logic [CW-1:0] need;
  logic          overflow;
  logic          bad;
  logic [7:0]    new_hdr;
  logic [15:0]   new_enc;
  logic          gate;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [31:0]   payload_word;
  logic          jump;
  logic [CW-1:0] fill_pad;
  logic [7:0]    tlv_byte;
  logic          addr_bad;
  logic [MW-1:0] mod_inc;
  logic [MW-1:0] mod_dec;

  always_comb begin
    cw           = ucode_word(pc);
    payload_word = {20'd0, r_payload};
    is_short     = r_payload <= 12'd255;
    start_pos    = (enc_size == 16'd0) ? FW'(4) : fill - FW'(1);
    need         = CW'(start_pos) + (is_short ? CW'(5) : CW'(8)) + CW'(r_payload);
    overflow     = need > CW'(STORE_BYTES);
    bad          = open_flag || overflow;
    new_hdr      = TNF_WELL_KNOWN | FLAG_ME
                 | ((start_pos == FW'(4)) ? FLAG_MB : 8'h00)
                 | (is_short ? FLAG_SR : 8'h00);
    new_enc      = enc_size + (is_short ? 16'd4 : 16'd7) + 16'(r_payload);
    mod_inc      = (fill_mod == MOD_TOP) ? '0 : fill_mod + MW'(1);
    mod_dec      = (fill_mod == '0) ? MOD_TOP : fill_mod - MW'(1);

    case (cw.op)
      OP_BEGIN: gate = !bad && (last_pos != '0);
      OP_BODY:  gate = open_flag;
      default:  gate = 1'b1;
    endcase
    waddr = cw.at_last ? last_pos[AW-1:0] : fill[AW-1:0];
    we    = cw.wen && gate && (cw.at_last || (fill < FW'(STORE_BYTES)));

    case (cw.wsrc)
      WS_OLDHDR: wdata = last_hdr & ~FLAG_ME;
      WS_HDR:    wdata = last_hdr;
      WS_TLEN:   wdata = TYPE_LEN;
      WS_LEN3:   wdata = payload_word[31:24];
      WS_LEN2:   wdata = payload_word[23:16];
      WS_LEN1:   wdata = payload_word[15:8];
      WS_LEN0:   wdata = payload_word[7:0];
      WS_TYPE:   wdata = (r_action == ACT_TEXT) ? TYPE_TEXT : TYPE_URI;
      WS_STAT:   wdata = (r_action == ACT_TEXT) ? {2'b00, r_stat} : 8'h00;
      WS_END:    wdata = TLV_END;
      WS_DATA:   wdata = r_data;
      default:   wdata = 8'h00;
    endcase

    case (cw.cond)
      CD_ALWAYS: jump = 1'b1;
      CD_BAD:    jump = bad;
      CD_SHORT:  jump = is_short;
      CD_BLEN:   jump = r_blen != 11'd0;
      CD_STAY:   jump = !open_flag || (remaining != 11'd1);
      default:   jump = 1'b0;
    endcase

    fill_pad = CW'(fill) + ((fill_mod == '0) ? CW'(0) : CW'(PAD_BLOCK) - CW'(fill_mod));

    // TLV head bytes live in registers, derived from the encoded size
    case (r_addr[1:0])
      2'd0:    tlv_byte = TLV_NDEF;
      2'd1:    tlv_byte = (enc_size == 16'd0) ? 8'h00 : TLV_LONG;
      2'd2:    tlv_byte = (enc_size == 16'd0) ? TLV_END : enc_size[15:8];
      default: tlv_byte = enc_size[7:0];
    endcase
    addr_bad = (CW'(r_addr) >= CW'(fill)) || (CW'(r_addr) >= CW'(STORE_BYTES));
  end

  // byte store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[AW'(r_addr)];
  end

  // latch the request on accept
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      r_action  <= action;
      r_payload <= {1'b0, body_length} + 12'd1;
      r_blen    <= body_length;
      r_stat    <= record_status;
      r_data    <= data_byte;
      r_addr    <= read_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      pc        <= PC_FIN;
      fill      <= FW'(3);
      fill_mod  <= MOD_THREE;
      enc_size  <= 16'd0;
      last_pos  <= '0;
      remaining <= 11'd0;
      open_flag <= 1'b0;
      status    <= STS_OK;
      read_byte <= 8'h00;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          busy      <= 1'b1;
          pc        <= entry_step(action);
          status    <= STS_OK;
          read_byte <= 8'h00;
        end
      end else begin
        pc <= jump ? cw.target : pc + 5'd1;
        if (we && cw.inc) begin
          fill     <= fill + FW'(1);
          fill_mod <= mod_inc;
        end
        case (cw.op)
          OP_BEGIN: begin
            if (open_flag) begin
              status <= STS_SEQUENCE;
            end else if (overflow) begin
              status <= STS_OVERFLOW;
            end else begin
              fill     <= start_pos;
              fill_mod <= (enc_size == 16'd0) ? MOD_FOUR : mod_dec;
              enc_size <= new_enc;
              last_pos <= start_pos;
              last_hdr <= new_hdr;
            end
          end
          OP_OPEN: begin
            remaining <= r_blen;
            open_flag <= r_blen != 11'd0;
          end
          OP_BODY: begin
            if (!open_flag) begin
              status <= STS_SEQUENCE;
            end else if (remaining != 11'd0) begin
              remaining <= remaining - 11'd1;
            end
          end
          OP_CLOSE: begin
            open_flag <= 1'b0;
          end
          OP_CLEAR: begin
            fill      <= FW'(3);
            fill_mod  <= MOD_THREE;
            enc_size  <= 16'd0;
            last_pos  <= '0;
            remaining <= 11'd0;
            open_flag <= 1'b0;
          end
          OP_READ: begin
            if (addr_bad) begin
              status <= STS_RANGE;
            end
          end
          OP_RDOUT: begin
            if (status == STS_OK) begin
              read_byte <= (r_addr < 10'd4) ? tlv_byte : rd_q;
            end
          end
          OP_BAD: begin
            status <= STS_SEQUENCE;
          end
          OP_FIN: begin
            busy <= 1'b0;
            done <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result length fields, sampled when the program finishes
  always_ff @(posedge clk) begin
    if (busy && (cw.op == OP_FIN)) begin
      message_length <= 11'(fill);
      padded_length  <= 11'(fill_pad);
      record_open    <= open_flag;
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("done without a finished program");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start the program");

  // the closing step runs with the count already at zero
  a_open_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (open_flag && !busy) |-> (remaining != 11'd0))
    else $error("record open with no body bytes left");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(STORE_BYTES))
    else $error("fill length beyond the store");

  a_fail_no_byte: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STS_OK)) |-> (read_byte == 8'h00))
    else $error("read byte on a failed request");

endmodule
`default_nettype wire
